[sv/krt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record table package
// Shared sizes, operation and status codes, and the queued command record.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int DEPTH       = 16;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int OP_W        = 3;
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 64;
  localparam int STAT_W      = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_DELETE = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ACT,
    S_SHIFT,
    S_LIST
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

endpackage

[sv/krt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record table front end
// Accepts items, drops unknown operation codes and queues the rest.
// ----------------------------------------------------------------------------
module krt_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [krt_pkg::OP_W-1:0]  operation_i,
  input  logic signed [krt_pkg::KEY_W-1:0] key_i,
  input  logic [krt_pkg::PAY_W-1:0] payload_i,
  output logic                      cmd_valid_o,
  output krt_pkg::cmd_t             cmd_o,
  input  logic                      cmd_pop_i
);
  import krt_pkg::*;

  cmd_t           queue_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] fill_q, fill_d;
  logic           full;
  logic           op_ok;
  logic           push;
  logic           pop;

  assign full        = (fill_q == QCW'(QUEUE_DEPTH));
  assign op_ok       = (operation_i <= OP_W'(OP_LIST));
  assign in_stall_o  = full;
  // Unknown codes are accepted but never reach the queue.
  assign push        = in_valid_i && !full && op_ok;
  assign pop         = cmd_pop_i && (fill_q != '0);
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= '{op: op_e'(operation_i), key: key_i, payload: payload_i};
    end
  end

endmodule

[sv/krt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record table back end
// Walks the entry memory to search, compact and list, and owns the result
// register.
// ----------------------------------------------------------------------------
module krt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  krt_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [krt_pkg::STAT_W-1:0]  status_o,
  output logic signed [krt_pkg::KEY_W-1:0] found_key_o,
  output logic [krt_pkg::PAY_W-1:0]   found_payload_o,
  output logic                        last_o
);
  import krt_pkg::*;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic          hit_q, hit_d;
  logic          rdv_q, rdv_d;
  logic [AW-1:0] rd_idx_q;
  entry_t        rd_q;
  entry_t        mem_q [DEPTH];

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic                    emit;
  status_e                 e_status;
  logic signed [KEY_W-1:0] e_key;
  logic [PAY_W-1:0]        e_pay;
  logic                    e_last;

  logic                    out_valid_q, out_valid_d;
  status_e                 status_q;
  logic signed [KEY_W-1:0] fkey_q;
  logic [PAY_W-1:0]        fpay_q;
  logic                    last_q;

  logic out_free;
  logic key_match;
  logic idx_more;
  logic list_last;
  logic is_full;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign key_match = rdv_q && (rd_q.key == cmd_q.key);
  assign idx_more  = (idx_q < count_q);
  assign list_last = (CW'(rd_idx_q) == count_q - 1'b1);
  assign is_full   = (count_q == CW'(DEPTH));
  assign rd_addr   = idx_q[AW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_LIST) begin
            state_d = (count_q == '0) ? S_ACT : S_LIST;
          end else if (cmd_i.op == OP_INSERT && is_full) begin
            state_d = S_ACT;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (key_match || !idx_more) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        if (out_free) begin
          state_d = (cmd_q.op == OP_DELETE && hit_q) ? S_SHIFT : S_IDLE;
        end
      end
      S_SHIFT: begin
        if (!idx_more) begin
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (rdv_q && out_free && list_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cmd_pop_o = 1'b0;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    count_d   = count_q;
    hit_d     = hit_q;
    rdv_d     = rdv_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = rd_idx_q;
    wr_data   = '{key: cmd_q.key, payload: cmd_q.payload};
    emit      = 1'b0;
    e_status  = STAT_OK;
    e_key     = cmd_q.key;
    e_pay     = '0;
    e_last    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          idx_d = '0;
          rdv_d = 1'b0;
          hit_d = 1'b0;
        end
      end
      S_SEARCH: begin
        if (key_match) begin
          hit_d = 1'b1;
        end else if (idx_more) begin
          rd_en = 1'b1;
          idx_d = idx_q + 1'b1;
          rdv_d = 1'b1;
        end else begin
          hit_d = 1'b0;
        end
      end
      S_ACT: begin
        if (out_free) begin
          emit = 1'b1;
          unique case (cmd_q.op)
            OP_INSERT: begin
              if (is_full) begin
                e_status = STAT_FULL;
              end else if (hit_q) begin
                e_status = STAT_DUP;
                e_key    = rd_q.key;
                e_pay    = rd_q.payload;
              end else begin
                e_pay   = cmd_q.payload;
                wr_en   = 1'b1;
                wr_addr = count_q[AW-1:0];
                count_d = count_q + 1'b1;
              end
            end
            OP_UPDATE: begin
              if (hit_q) begin
                e_pay = cmd_q.payload;
                wr_en = 1'b1;
              end else begin
                e_status = STAT_NOTFOUND;
              end
            end
            OP_DELETE: begin
              if (hit_q) begin
                e_key = rd_q.key;
                e_pay = rd_q.payload;
                idx_d = CW'(rd_idx_q) + 1'b1;
                rdv_d = 1'b0;
              end else begin
                e_status = STAT_NOTFOUND;
              end
            end
            OP_LOOKUP: begin
              if (hit_q) begin
                e_key = rd_q.key;
                e_pay = rd_q.payload;
              end else begin
                e_status = STAT_NOTFOUND;
              end
            end
            OP_LIST: begin
              e_status = STAT_EMPTY;
              e_key    = '0;
            end
            default: e_status = STAT_NOTFOUND;
          endcase
        end
      end
      S_SHIFT: begin
        // Each entry read one cycle is written one slot lower the next.
        if (rdv_q) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_q - 1'b1;
          wr_data = rd_q;
        end
        if (idx_more) begin
          rd_en = 1'b1;
          idx_d = idx_q + 1'b1;
          rdv_d = 1'b1;
        end else begin
          rdv_d   = 1'b0;
          count_d = count_q - 1'b1;
        end
      end
      S_LIST: begin
        if (rdv_q && out_free) begin
          emit   = 1'b1;
          e_key  = rd_q.key;
          e_pay  = rd_q.payload;
          e_last = list_last;
          rdv_d  = 1'b0;
        end
        if (idx_more && (!rdv_q || out_free)) begin
          rd_en = 1'b1;
          idx_d = idx_q + 1'b1;
          rdv_d = 1'b1;
        end
      end
      default: begin
        rdv_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      hit_q       <= hit_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (emit) begin
      status_q <= e_status;
      fkey_q   <= e_key;
      fpay_q   <= e_pay;
      last_q   <= e_last;
    end
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign found_key_o     = fkey_q;
  assign found_payload_o = fpay_q;
  assign last_o          = last_q;

endmodule

[sv/keyed_record_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record table core
// A packed table of key and payload entries with insert, update, delete,
// lookup and list operations.
// ----------------------------------------------------------------------------
// Each item carries an operation, a key and a payload. Insert, update,
// delete and lookup each give one result item. List gives one result per
// stored entry in slot order, with last set on the final one, or a single
// "table empty" result. Items with an operation code above list are taken
// and dropped without any result. Entries are searched one per cycle through
// an entry memory with one read port, one write port and a registered read.
// A keyed operation examines entries until the key matches or every stored
// entry has been seen. An insert into a full table skips the search. A
// delete then moves the later entries down one slot to keep the table packed.
// A list delivers one result per cycle while the output is not stalled. The
// front end queues up to two items, so new items are taken while the back
// end works and while a result waits to be collected.
// ----------------------------------------------------------------------------
module keyed_record_table_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [krt_pkg::OP_W-1:0]    operation_i,
  input  logic signed [krt_pkg::KEY_W-1:0] key_i,
  input  logic [krt_pkg::PAY_W-1:0]   payload_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [krt_pkg::STAT_W-1:0]  status_o,
  output logic signed [krt_pkg::KEY_W-1:0] found_key_o,
  output logic [krt_pkg::PAY_W-1:0]   found_payload_o,
  output logic                        last_o
);
  import krt_pkg::*;

  // Queue between the front end and the engine.
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  krt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .payload_i   (payload_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The engine owns the entry memory and the result register.
  krt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_key_o     (found_key_o),
    .found_payload_o (found_payload_o),
    .last_o          (last_o)
  );

endmodule
